>>> src/plc_pkg.sv
// Shared types and constants for the piecewise linear curve block.
// Depends on nothing; imported by plc_req_if, plc_front, plc_back and the top.
`timescale 1ns / 1ps

package plc_pkg;

   // Width of the points_in_use register and of the scan counters
   localparam int COUNT_WIDTH = 5;
   // Width of the breakpoint slot field of a load transaction
   localparam int INDEX_WIDTH = 4;

   // Meaning of the action field of an input transaction
   typedef enum logic [0:0] {
      ACT_EVALUATE = 1'b0,
      ACT_LOAD     = 1'b1
   } action_type;

   // Command classes passed from the front end to the back end
   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_EVAL  = 2'd1,
      CMD_EMPTY = 2'd2
   } cmd_op_type;

   // Control part of one queued command
   typedef struct packed {
      cmd_op_type             op;
      logic [COUNT_WIDTH-1:0] count;
      logic [INDEX_WIDTH-1:0] index;
   } cmd_ctrl_type;

   localparam int CMD_CTRL_WIDTH = $bits(cmd_ctrl_type);

endpackage

>>> src/plc_req_if.sv
// Input channel of the curve block: valid/ready handshake with load and
// evaluate payload. Depends on plc_pkg.
`timescale 1ns / 1ps

interface plc_req_if #(
   parameter int DATA_WIDTH = 32
);
   import plc_pkg::*;

   logic                          valid;
   logic                          ready;
   logic                          action;
   logic signed [DATA_WIDTH-1:0]  sample;
   logic [INDEX_WIDTH-1:0]        point_index;
   logic signed [DATA_WIDTH-1:0]  point_x;
   logic signed [DATA_WIDTH-1:0]  point_y;

   modport source (
      output valid, action, sample, point_index, point_x, point_y,
      input  ready
   );

   modport sink (
      input  valid, action, sample, point_index, point_x, point_y,
      output ready
   );

endinterface

>>> src/plc_rsp_if.sv
// Result channel of the curve block: valid/ready handshake carrying the
// curve value and the empty-table flag. No package dependency.
`timescale 1ns / 1ps

interface plc_rsp_if #(
   parameter int DATA_WIDTH = 32
);
   logic                          valid;
   logic                          ready;
   logic signed [DATA_WIDTH-1:0]  curve_value;
   logic                          table_empty;

   modport source (
      output valid, curve_value, table_empty,
      input  ready
   );

   modport sink (
      input  valid, curve_value, table_empty,
      output ready
   );

endinterface

>>> src/plc_front.sv
// Front end: accepts input transactions, classifies them into commands and
// queues all but out-of-range loads. Depends on plc_pkg and plc_req_if.
`timescale 1ns / 1ps

module plc_front #(
   parameter int DATA_WIDTH = 32,
   parameter int MAX_POINTS = 16
) (
   plc_req_if.sink                        req,
   input  logic [plc_pkg::COUNT_WIDTH-1:0] points_in_use,
   output logic                           push_valid,
   input  logic                           push_ready,
   output plc_pkg::cmd_ctrl_type          push_ctrl,
   output logic [DATA_WIDTH-1:0]          push_word_a,
   output logic [DATA_WIDTH-1:0]          push_word_b
);
   import plc_pkg::*;

   logic                   is_load;
   logic                   drop_load;
   logic [COUNT_WIDTH-1:0] clamped_count;

   // Classify the transaction and clamp the point count
   always_comb begin
      is_load       = (action_type'(req.action) == ACT_LOAD);
      drop_load     = is_load && (int'(req.point_index) >= MAX_POINTS);
      clamped_count = (int'(points_in_use) > MAX_POINTS) ?
                      COUNT_WIDTH'(MAX_POINTS) : points_in_use;

      push_ctrl.count = clamped_count;
      push_ctrl.index = req.point_index;
      priority if (is_load) begin
         push_ctrl.op = CMD_LOAD;
      end else if (clamped_count == '0) begin
         push_ctrl.op = CMD_EMPTY;
      end else begin
         push_ctrl.op = CMD_EVAL;
      end

      push_word_a = is_load ? req.point_x : req.sample;
      push_word_b = req.point_y;
   end

   // Drop loads to slots beyond the table without touching the queue
   assign push_valid = req.valid && !drop_load;
   assign req.ready  = push_ready || drop_load;

endmodule

>>> src/plc_queue.sv
// Two-entry command queue between the front end and the back end.
// Generic payload width; no package dependency.
`timescale 1ns / 1ps

module plc_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   localparam int DEPTH = 2;
   localparam int PTR_WIDTH = $clog2(DEPTH);
   localparam int FILL_WIDTH = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]      slot_ff [DEPTH];
   logic [PTR_WIDTH-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_WIDTH-1:0] fill_ff, fill_in;
   logic                  do_push, do_pop;

   assign push_ready = (fill_ff != FILL_WIDTH'(DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];

   // Advance pointers and fill level
   always_comb begin
      do_push   = push_valid && push_ready;
      do_pop    = pop_valid && pop_ready;
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

>>> src/plc_muldiv.sv
// Iterative unit computing a * b / d for unsigned operands: shift-add
// multiply, one bit a cycle, then restoring division, one bit a cycle.
// No package dependency.
`timescale 1ns / 1ps

module plc_muldiv #(
   parameter int OP_WIDTH = 33
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [OP_WIDTH-1:0] op_a,
   input  logic [OP_WIDTH-1:0] op_b,
   input  logic [OP_WIDTH-1:0] op_d,
   output logic                done,
   output logic [OP_WIDTH-1:0] quotient,
   output logic                overflow
);
   localparam int STEP_WIDTH = $clog2(OP_WIDTH);

   typedef enum logic [1:0] {
      MD_IDLE,
      MD_MUL,
      MD_CHECK,
      MD_DIV
   } md_state_type;

   md_state_type            state_ff, state_in;
   logic [2*OP_WIDTH-1:0]   acc_ff, acc_in;
   logic [OP_WIDTH-1:0]     mplier_ff, mplier_in;
   logic [OP_WIDTH-1:0]     mcand_ff, mcand_in;
   logic [OP_WIDTH-1:0]     div_ff, div_in;
   logic [OP_WIDTH-1:0]     rem_ff, rem_in;
   logic [OP_WIDTH-1:0]     quot_ff, quot_in;
   logic [STEP_WIDTH-1:0]   step_ff, step_in;
   logic                    ovf_ff, ovf_in;
   logic                    done_ff, done_in;
   logic [OP_WIDTH:0]       rem_shift;
   logic [OP_WIDTH:0]       rem_diff;
   logic                    rem_ge;

   assign done     = done_ff;
   assign quotient = quot_ff;
   assign overflow = ovf_ff;

   always_comb begin
      state_in  = state_ff;
      acc_in    = acc_ff;
      mplier_in = mplier_ff;
      mcand_in  = mcand_ff;
      div_in    = div_ff;
      rem_in    = rem_ff;
      quot_in   = quot_ff;
      step_in   = step_ff;
      ovf_in    = ovf_ff;
      done_in   = 1'b0;
      rem_shift = {rem_ff, quot_ff[OP_WIDTH-1]};
      rem_diff  = rem_shift - {1'b0, div_ff};
      rem_ge    = (rem_shift >= {1'b0, div_ff});

      unique case (state_ff)
         MD_IDLE: begin
            if (start) begin
               mplier_in = op_a;
               mcand_in  = op_b;
               div_in    = op_d;
               acc_in    = '0;
               step_in   = STEP_WIDTH'(OP_WIDTH - 1);
               state_in  = MD_MUL;
            end
         end
         // Accumulate the product, multiplier MSB first
         MD_MUL: begin
            acc_in    = {acc_ff[2*OP_WIDTH-2:0], 1'b0} +
                        (mplier_ff[OP_WIDTH-1] ? {{OP_WIDTH{1'b0}}, mcand_ff} : '0);
            mplier_in = {mplier_ff[OP_WIDTH-2:0], 1'b0};
            if (step_ff == '0) begin
               state_in = MD_CHECK;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         // A high half not below the divisor means the quotient is too wide
         MD_CHECK: begin
            if (acc_ff[2*OP_WIDTH-1:OP_WIDTH] >= div_ff) begin
               ovf_in   = 1'b1;
               done_in  = 1'b1;
               state_in = MD_IDLE;
            end else begin
               ovf_in   = 1'b0;
               rem_in   = acc_ff[2*OP_WIDTH-1:OP_WIDTH];
               quot_in  = acc_ff[OP_WIDTH-1:0];
               step_in  = STEP_WIDTH'(OP_WIDTH - 1);
               state_in = MD_DIV;
            end
         end
         // One restoring division step, quotient bits shift in from the right
         MD_DIV: begin
            rem_in  = rem_ge ? rem_diff[OP_WIDTH-1:0] : rem_shift[OP_WIDTH-1:0];
            quot_in = {quot_ff[OP_WIDTH-2:0], rem_ge};
            if (step_ff == '0) begin
               done_in  = 1'b1;
               state_in = MD_IDLE;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         default: begin
            state_in = MD_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      mplier_ff <= mplier_in;
      mcand_ff  <= mcand_in;
      div_ff    <= div_in;
      rem_ff    <= rem_in;
      quot_ff   <= quot_in;
      step_ff   <= step_in;
      ovf_ff    <= ovf_in;
      if (reset) begin
         state_ff <= MD_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

endmodule

>>> src/plc_back.sv
// Back end: holds the breakpoint table, scans it for evaluate commands,
// drives the interpolation unit and registers the result transaction.
// Depends on plc_pkg, plc_rsp_if and plc_muldiv.
`timescale 1ns / 1ps

module plc_back #(
   parameter int DATA_WIDTH = 32,
   parameter int MAX_POINTS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pop_valid,
   output logic                  pop_ready,
   input  plc_pkg::cmd_ctrl_type pop_ctrl,
   input  logic [DATA_WIDTH-1:0] pop_word_a,
   input  logic [DATA_WIDTH-1:0] pop_word_b,
   plc_rsp_if.source             rsp
);
   import plc_pkg::*;

   localparam int W = DATA_WIDTH;
   localparam int ADDR_WIDTH = $clog2(MAX_POINTS);
   localparam logic signed [W+2:0] SUM_MAX = {4'b0000, {(W-1){1'b1}}};
   localparam logic signed [W+2:0] SUM_MIN = {4'b1111, {(W-1){1'b0}}};
   localparam logic [W-1:0] OUT_MAX = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] OUT_MIN = {1'b1, {(W-1){1'b0}}};

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SCAN,
      BK_DIFF,
      BK_START,
      BK_WAIT,
      BK_EMIT
   } bk_state_type;

   // Breakpoint table, one word of {x, y} per slot
   logic [2*W-1:0]          table_mem [MAX_POINTS];
   logic [2*W-1:0]          entry_ff;
   logic [ADDR_WIDTH-1:0]   rd_addr;
   logic [ADDR_WIDTH-1:0]   wr_addr;
   logic                    wr_en;

   bk_state_type            state_ff, state_in;
   logic signed [W-1:0]     sample_ff, sample_in;
   logic [COUNT_WIDTH-1:0]  count_ff, count_in;
   logic [COUNT_WIDTH-1:0]  idx_ff, idx_in;
   logic signed [W-1:0]     prev_x_ff, prev_x_in;
   logic signed [W-1:0]     prev_y_ff, prev_y_in;
   logic [W:0]              dx_ff, dx_in;
   logic [W:0]              din_ff, din_in;
   logic [W:0]              dy_ff, dy_in;
   logic                    neg_ff, neg_in;
   logic [W-1:0]            result_ff, result_in;
   logic                    empty_ff, empty_in;
   logic                    out_valid_ff, out_valid_in;
   logic [W-1:0]            out_value_ff, out_value_in;
   logic                    out_empty_ff, out_empty_in;

   logic signed [W-1:0]     entry_x, entry_y;
   logic                    md_start, md_done, md_overflow;
   logic [W:0]              md_a, md_b, md_d, md_quot;
   logic signed [W+2:0]     py_ext, q_ext, sum;
   logic                    out_free;

   plc_muldiv #(
      .OP_WIDTH (W + 1)
   ) u_muldiv (
      .clock    (clock),
      .reset    (reset),
      .start    (md_start),
      .op_a     (md_a),
      .op_b     (md_b),
      .op_d     (md_d),
      .done     (md_done),
      .quotient (md_quot),
      .overflow (md_overflow)
   );

   assign pop_ready       = (state_ff == BK_IDLE);
   assign rsp.valid       = out_valid_ff;
   assign rsp.curve_value = out_value_ff;
   assign rsp.table_empty = out_empty_ff;

   always_comb begin
      entry_x = entry_ff[2*W-1:W];
      entry_y = entry_ff[W-1:0];
      py_ext  = {{3{prev_y_ff[W-1]}}, prev_y_ff};
      q_ext   = {2'b00, md_quot};
      sum     = neg_ff ? py_ext - q_ext : py_ext + q_ext;
      md_a    = dy_ff[W] ? -dy_ff : dy_ff;
      md_b    = din_ff[W] ? -din_ff : din_ff;
      md_d    = dx_ff[W] ? -dx_ff : dx_ff;
      md_start = 1'b0;
      wr_en   = 1'b0;
      wr_addr = ADDR_WIDTH'(pop_ctrl.index);
      out_free = !out_valid_ff || rsp.ready;

      state_in     = state_ff;
      sample_in    = sample_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      dx_in        = dx_ff;
      din_in       = din_ff;
      dy_in        = dy_ff;
      neg_in       = neg_ff;
      result_in    = result_ff;
      empty_in     = empty_ff;
      out_value_in = out_value_ff;
      out_empty_in = out_empty_ff;
      out_valid_in = out_valid_ff && !rsp.ready;

      unique case (state_ff)
         // Take the next command from the queue
         BK_IDLE: begin
            if (pop_valid) begin
               unique case (pop_ctrl.op)
                  CMD_LOAD: begin
                     wr_en = 1'b1;
                  end
                  CMD_EMPTY: begin
                     result_in = '0;
                     empty_in  = 1'b1;
                     state_in  = BK_EMIT;
                  end
                  CMD_EVAL: begin
                     sample_in = pop_word_a;
                     count_in  = pop_ctrl.count;
                     idx_in    = '0;
                     empty_in  = 1'b0;
                     state_in  = BK_SCAN;
                  end
                  default: begin
                     state_in = BK_IDLE;
                  end
               endcase
            end
         end
         // Compare the sample against one breakpoint a cycle
         BK_SCAN: begin
            priority if (sample_ff < entry_x) begin
               if (idx_ff == '0) begin
                  result_in = entry_y;
                  state_in  = BK_EMIT;
               end else begin
                  state_in = BK_DIFF;
               end
            end else if ((sample_ff == entry_x) || (idx_ff == count_ff - 1'b1)) begin
               result_in = entry_y;
               state_in  = BK_EMIT;
            end else begin
               prev_x_in = entry_x;
               prev_y_in = entry_y;
               idx_in    = idx_ff + 1'b1;
            end
         end
         // Register the spans of the bracketing segment
         BK_DIFF: begin
            dx_in    = {entry_x[W-1], entry_x} - {prev_x_ff[W-1], prev_x_ff};
            din_in   = {sample_ff[W-1], sample_ff} - {prev_x_ff[W-1], prev_x_ff};
            dy_in    = {entry_y[W-1], entry_y} - {prev_y_ff[W-1], prev_y_ff};
            state_in = BK_START;
         end
         // Zero span answers zero, else launch the product and quotient
         BK_START: begin
            if (dx_ff == '0) begin
               result_in = '0;
               state_in  = BK_EMIT;
            end else begin
               neg_in   = dx_ff[W] ^ din_ff[W] ^ dy_ff[W];
               md_start = 1'b1;
               state_in = BK_WAIT;
            end
         end
         // Wait for the quotient, apply it with its sign to the lower ordinate and saturate
         BK_WAIT: begin
            if (md_done) begin
               priority if (md_overflow) begin
                  result_in = neg_ff ? OUT_MIN : OUT_MAX;
               end else if (sum > SUM_MAX) begin
                  result_in = OUT_MAX;
               end else if (sum < SUM_MIN) begin
                  result_in = OUT_MIN;
               end else begin
                  result_in = sum[W-1:0];
               end
               state_in = BK_EMIT;
            end
         end
         // Hand the result to the output register once it is free
         BK_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_value_in = result_ff;
               out_empty_in = empty_ff;
               state_in     = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase

      rd_addr = ADDR_WIDTH'(idx_in);
   end

   // Table write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= {pop_word_a, pop_word_b};
      end
      entry_ff <= table_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      sample_ff    <= sample_in;
      count_ff     <= count_in;
      idx_ff       <= idx_in;
      prev_x_ff    <= prev_x_in;
      prev_y_ff    <= prev_y_in;
      dx_ff        <= dx_in;
      din_ff       <= din_in;
      dy_ff        <= dy_in;
      neg_ff       <= neg_in;
      result_ff    <= result_in;
      empty_ff     <= empty_in;
      out_value_ff <= out_value_in;
      out_empty_ff <= out_empty_in;
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

>>> src/piecewise_linear_curve.sv
// Piecewise linear curve lookup. A load goes through the queue and is written to the table
// when the back end pops it. An evaluate that the scan decides at breakpoint k passes the
// pop, a scan step for each breakpoint up to k, and the emit; emit waits for a free output.
// Interpolation adds span, launch and wait states for the shift-add multiply and divide.
// The back end takes one command at a time; a two-entry queue keeps input open.
// Reset (synchronous) clears control and points_in_use; the table holds no reset.
`timescale 1ns / 1ps

module piecewise_linear_curve #(
   parameter int MAX_POINTS = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   plc_req_if.sink     req_chan,
   plc_rsp_if.source   rsp_chan,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import plc_pkg::*;

   localparam int QUEUE_WIDTH = CMD_CTRL_WIDTH + 2 * DATA_WIDTH;

   typedef enum logic [0:0] {
      REG_POINTS_IN_USE = 1'b0
   } csr_reg_type;

   logic [COUNT_WIDTH-1:0]  points_in_use_ff, points_in_use_in;
   logic                    csr_write;
   logic                    reg_hit;

   logic                    push_valid, push_ready;
   cmd_ctrl_type            push_ctrl;
   logic [DATA_WIDTH-1:0]   push_word_a, push_word_b;
   logic                    pop_valid, pop_ready;
   logic [QUEUE_WIDTH-1:0]  pop_data;
   cmd_ctrl_type            pop_ctrl;

   // Register access: write on the access phase, read back the count
   assign csr_pready = 1'b1;
   always_comb begin
      reg_hit          = (csr_paddr[2] == REG_POINTS_IN_USE);
      csr_write        = csr_psel && csr_penable && csr_pwrite && csr_pready;
      points_in_use_in = (csr_write && reg_hit) ?
                         csr_pwdata[COUNT_WIDTH-1:0] : points_in_use_ff;
      csr_prdata       = reg_hit ? {{(32-COUNT_WIDTH){1'b0}}, points_in_use_ff} : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         points_in_use_ff <= '0;
      end else begin
         points_in_use_ff <= points_in_use_in;
      end
   end

   plc_front #(
      .DATA_WIDTH (DATA_WIDTH),
      .MAX_POINTS (MAX_POINTS)
   ) u_front (
      .req           (req_chan),
      .points_in_use (points_in_use_ff),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_ctrl     (push_ctrl),
      .push_word_a   (push_word_a),
      .push_word_b   (push_word_b)
   );

   plc_queue #(
      .WIDTH (QUEUE_WIDTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_ctrl, push_word_a, push_word_b}),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   assign pop_ctrl = cmd_ctrl_type'(pop_data[QUEUE_WIDTH-1 -: CMD_CTRL_WIDTH]);

   plc_back #(
      .DATA_WIDTH (DATA_WIDTH),
      .MAX_POINTS (MAX_POINTS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_ctrl   (pop_ctrl),
      .pop_word_a (pop_data[2*DATA_WIDTH-1:DATA_WIDTH]),
      .pop_word_b (pop_data[DATA_WIDTH-1:0]),
      .rsp        (rsp_chan)
   );

endmodule
